/* src/blg_pkg.sv */
// ----------------------------------------------------------------------------
// blg_pkg
// Shared types and constants of the Bresenham line generator.
// ----------------------------------------------------------------------------
package blg_pkg;

    localparam int SIZE_BITS      = 10;
    localparam int COLOR_BITS     = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RST  = 10'd240;
    localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RST = 10'd320;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } opcode_t;

    // status of the pixel the stepper offers in the current cycle
    typedef struct packed {
        logic emit;
        logic on_screen;
        logic last;
    } blg_flags_t;

endpackage

/* src/blg_stepper.sv */
// ----------------------------------------------------------------------------
// blg_stepper
// Line state and one Bresenham step per accepted advance item.
// ----------------------------------------------------------------------------
module blg_stepper #(
    parameter int COORD_BITS = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic                           opcode,
    input  logic [COORD_BITS-1:0]          start_x,
    input  logic [COORD_BITS-1:0]          start_y,
    input  logic [COORD_BITS-1:0]          end_x,
    input  logic [COORD_BITS-1:0]          end_y,
    input  logic [blg_pkg::COLOR_BITS-1:0] pen_color,
    input  logic [blg_pkg::SIZE_BITS-1:0]  screen_width,
    input  logic [blg_pkg::SIZE_BITS-1:0]  screen_height,
    output logic [COORD_BITS-1:0]          cur_x,
    output logic [COORD_BITS-1:0]          cur_y,
    output logic [blg_pkg::COLOR_BITS-1:0] cur_color,
    output blg_pkg::blg_flags_t            flags
);
    import blg_pkg::*;

    localparam int DEC_BITS = COORD_BITS + 3;
    localparam int CMP_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;

    logic                  active_reg, active_next;
    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_BITS-1:0] target_x_reg, target_x_next;
    logic [COORD_BITS-1:0] target_y_reg, target_y_next;
    logic [COORD_BITS-1:0] delta_x_reg, delta_x_next;
    logic [COORD_BITS-1:0] delta_y_reg, delta_y_next;
    logic [1:0]            step_dirs_reg, step_dirs_next;
    logic signed [DEC_BITS-1:0] decision_reg, decision_next;
    logic [COLOR_BITS-1:0] line_color_reg, line_color_next;

    logic                  is_last;
    logic                  x_major;
    logic                  step_minor;
    logic [COORD_BITS-1:0] new_dx, new_dy;
    logic signed [DEC_BITS-1:0] new_major, new_minor;
    logic signed [DEC_BITS-1:0] cur_major, cur_minor;

    assign is_last    = (cursor_x_reg == target_x_reg) && (cursor_y_reg == target_y_reg);
    assign x_major    = delta_x_reg > delta_y_reg;
    assign step_minor = !decision_reg[DEC_BITS-1] && (decision_reg != '0);

    assign new_dx = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
    assign new_dy = (end_y >= start_y) ? end_y - start_y : start_y - end_y;

    assign new_major = $signed({3'b000, (new_dx > new_dy) ? new_dx : new_dy});
    assign new_minor = $signed({3'b000, (new_dx > new_dy) ? new_dy : new_dx});
    assign cur_major = $signed({3'b000, x_major ? delta_x_reg : delta_y_reg});
    assign cur_minor = $signed({3'b000, x_major ? delta_y_reg : delta_x_reg});

    always_comb
    begin
        active_next     = active_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        step_dirs_next  = step_dirs_reg;
        decision_next   = decision_reg;
        line_color_next = line_color_reg;
        if (take)
        begin
            if (opcode == OP_START)
            begin
                active_next     = 1'b1;
                cursor_x_next   = start_x;
                cursor_y_next   = start_y;
                target_x_next   = end_x;
                target_y_next   = end_y;
                delta_x_next    = new_dx;
                delta_y_next    = new_dy;
                step_dirs_next  = {end_y < start_y, end_x < start_x};
                decision_next   = (new_minor <<< 1) - new_major;
                line_color_next = pen_color;
            end
            else if (active_reg)
            begin
                if (is_last)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    // major axis always moves, minor axis only on a positive decision
                    if (x_major || step_minor)
                        cursor_x_next = step_dirs_reg[0] ? cursor_x_reg - 1'b1
                                                         : cursor_x_reg + 1'b1;
                    if (!x_major || step_minor)
                        cursor_y_next = step_dirs_reg[1] ? cursor_y_reg - 1'b1
                                                         : cursor_y_reg + 1'b1;
                    if (step_minor)
                        decision_next = decision_reg + (cur_minor <<< 1) - (cur_major <<< 1);
                    else
                        decision_next = decision_reg + (cur_minor <<< 1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            step_dirs_reg  <= '0;
            decision_reg   <= '0;
            line_color_reg <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            delta_x_reg    <= delta_x_next;
            delta_y_reg    <= delta_y_next;
            step_dirs_reg  <= step_dirs_next;
            decision_reg   <= decision_next;
            line_color_reg <= line_color_next;
        end
    end

    assign cur_x     = cursor_x_reg;
    assign cur_y     = cursor_y_reg;
    assign cur_color = line_color_reg;

    assign flags.emit      = (opcode == OP_ADVANCE) && active_reg;
    assign flags.on_screen = (CMP_BITS'(cursor_x_reg) < CMP_BITS'(screen_width))
                          && (CMP_BITS'(cursor_y_reg) < CMP_BITS'(screen_height));
    assign flags.last      = is_last;

endmodule

/* src/bresenham_line_generator.sv */
// ----------------------------------------------------------------------------
// bresenham_line_generator
// Integer line rasteriser, one pixel per advance item, all octants.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall): opcode start loads both endpoints
//   and the pen colour and gives no pixel; opcode advance gives the next pixel
//   of the line, or nothing when no line is loaded. A start drops any line
//   still being drawn.
//   Pixel channel (pix_valid / pix_stall): position, colour, on-screen flag
//   against the screen size registers, and last on the second endpoint.
//   Config channel (cfg_valid / cfg_ready): index 0 screen width, index 1
//   screen height; always ready, write only while idle.
//   A taken advance item registers its pixel in the output or skid entry.
//   Throughput: one item per cycle while cmd_stall is low; the line state is
//   stepped combinationally, so the only limit is the pixel channel.
//   A two-entry output (register plus skid) lets a command be taken while a
//   pixel waits; cmd_stall rises only when both entries hold pixels.
//   Reset: no line loaded, pixel channel empty, screen size 240 x 320.
// ----------------------------------------------------------------------------
module bresenham_line_generator #(
    parameter int COORD_BITS = 9
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic                               opcode,
    input  logic [COORD_BITS-1:0]              start_x,
    input  logic [COORD_BITS-1:0]              start_y,
    input  logic [COORD_BITS-1:0]              end_x,
    input  logic [COORD_BITS-1:0]              end_y,
    input  logic [blg_pkg::COLOR_BITS-1:0]     pen_color,
    output logic                               pix_valid,
    input  logic                               pix_stall,
    output logic [COORD_BITS-1:0]              pixel_x,
    output logic [COORD_BITS-1:0]              pixel_y,
    output logic [blg_pkg::COLOR_BITS-1:0]     pixel_color,
    output logic                               on_screen,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [blg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [blg_pkg::SIZE_BITS-1:0]      cfg_data
);
    import blg_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
        logic                  on_screen;
        logic                  last;
    } pixel_t;

    logic [SIZE_BITS-1:0] screen_width_reg;
    logic [SIZE_BITS-1:0] screen_height_reg;

    logic       cmd_take;
    logic       res_fire;
    logic       out_taken;
    blg_flags_t flags;
    pixel_t     res;

    logic [COORD_BITS-1:0] cur_x, cur_y;
    logic [COLOR_BITS-1:0] cur_color;

    logic   out_valid_reg;
    logic   skid_valid_reg;
    pixel_t out_reg;
    pixel_t skid_reg;

    assign cmd_stall = skid_valid_reg;
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    blg_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (cmd_take),
        .opcode        (opcode),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .pen_color     (pen_color),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .cur_x         (cur_x),
        .cur_y         (cur_y),
        .cur_color     (cur_color),
        .flags         (flags)
    );

    assign res_fire  = cmd_take && flags.emit;
    assign out_taken = out_valid_reg && !pix_stall;

    assign res.x         = cur_x;
    assign res.y         = cur_y;
    assign res.color     = cur_color;
    assign res.on_screen = flags.on_screen;
    assign res.last      = flags.last;

    // control of the output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg && out_taken)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (res_fire && !out_taken && out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end

            if (res_fire)
                out_valid_reg <= 1'b1;
            else if (out_taken && !skid_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && out_taken)
            out_reg <= skid_reg;
        else if (res_fire && (out_taken || !out_valid_reg))
            out_reg <= res;

        if (res_fire && out_valid_reg && !out_taken)
            skid_reg <= res;
    end

    assign pix_valid   = out_valid_reg;
    assign pixel_x     = out_reg.x;
    assign pixel_y     = out_reg.y;
    assign pixel_color = out_reg.color;
    assign on_screen   = out_reg.on_screen;
    assign last        = out_reg.last;

    // skid entry only ever holds an item behind a waiting one
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(pix_stall) && $past(out_valid_reg))
        else $error("skid entry filled without a stalled output");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> out_valid_reg)
        else $error("pixel result lost");

    a_no_fire_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && skid_valid_reg && pix_stall) |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid entry overwritten while full");

endmodule

/* dv/bresenham_line_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_checker
// Watches the command, pixel and screen-size channels of the line generator.
// Keeps its own line stepper, predicts every pixel that an advance item
// should give, and compares each pixel taken with the oldest prediction.
// ----------------------------------------------------------------------------
module bresenham_line_checker
    import blg_pkg::*;
#(
    parameter int COORD_BITS = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  logic                      cmd_stall,
    input  logic                      opcode,
    input  logic [COORD_BITS-1:0]     start_x,
    input  logic [COORD_BITS-1:0]     start_y,
    input  logic [COORD_BITS-1:0]     end_x,
    input  logic [COORD_BITS-1:0]     end_y,
    input  logic [COLOR_BITS-1:0]     pen_color,
    input  logic                      pix_valid,
    input  logic                      pix_stall,
    input  logic [COORD_BITS-1:0]     pixel_x,
    input  logic [COORD_BITS-1:0]     pixel_y,
    input  logic [COLOR_BITS-1:0]     pixel_color,
    input  logic                      on_screen,
    input  logic                      last,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]      cfg_data,
    output int                        mismatches,
    output int                        outstanding,
    output int                        pixels_checked,
    output int                        lines_started
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
        logic                  on_scr;
        logic                  last;
    } pixel_t;

    pixel_t pixel_q[$];

    // line stepper state
    logic                  line_live;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [COORD_BITS-1:0] tgt_x;
    logic [COORD_BITS-1:0] tgt_y;
    logic [COORD_BITS:0]   span_x;
    logic [COORD_BITS:0]   span_y;
    logic                  x_down;
    logic                  y_down;
    int                    err;
    logic [COLOR_BITS-1:0] ink;
    logic [SIZE_BITS-1:0]  scr_w;
    logic [SIZE_BITS-1:0]  scr_h;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] v,
                                                     input logic down);
        return down ? v - 1'b1 : v + 1'b1;
    endfunction

    // Steps the line for one command item; returns 1 when a pixel comes out.
    function automatic bit step_line(input opcode_t op, output pixel_t px);
        px = '0;
        if (op == OP_START)
        begin
            cur_x  = start_x;
            cur_y  = start_y;
            tgt_x  = end_x;
            tgt_y  = end_y;
            x_down = end_x < start_x;
            y_down = end_y < start_y;
            span_x = x_down ? start_x - end_x : end_x - start_x;
            span_y = y_down ? start_y - end_y : end_y - start_y;
            if (span_x > span_y)
                err = 2 * int'(span_y) - int'(span_x);
            else
                err = 2 * int'(span_x) - int'(span_y);
            ink       = pen_color;
            line_live = 1'b1;
            return 1'b0;
        end
        if (!line_live)
            return 1'b0;

        px.x      = cur_x;
        px.y      = cur_y;
        px.color  = ink;
        px.on_scr = (cur_x < scr_w) && (cur_y < scr_h);
        px.last   = (cur_x == tgt_x) && (cur_y == tgt_y);
        if (px.last)
        begin
            line_live = 1'b0;
            return 1'b1;
        end

        if (span_x > span_y)
        begin
            cur_x = nudge(cur_x, x_down);
            if (err > 0)
            begin
                cur_y = nudge(cur_y, y_down);
                err += 2 * int'(span_y) - 2 * int'(span_x);
            end
            else
                err += 2 * int'(span_y);
        end
        else
        begin
            cur_y = nudge(cur_y, y_down);
            if (err > 0)
            begin
                cur_x = nudge(cur_x, x_down);
                err += 2 * int'(span_x) - 2 * int'(span_y);
            end
            else
                err += 2 * int'(span_x);
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got;
        pixel_t want;
        pixel_t fresh;
        string  bad;
        if (!rst_n)
        begin
            line_live = 1'b0;
            cur_x     = '0;
            cur_y     = '0;
            tgt_x     = '0;
            tgt_y     = '0;
            span_x    = '0;
            span_y    = '0;
            x_down    = 1'b0;
            y_down    = 1'b0;
            err       = 0;
            ink       = '0;
            scr_w     = SCREEN_WIDTH_RST;
            scr_h     = SCREEN_HEIGHT_RST;
            pixel_q.delete();
            mismatches     = 0;
            pixels_checked = 0;
            lines_started  = 0;
            outstanding   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SCREEN_WIDTH)
                    scr_w = cfg_data;
                else if (cfg_index == CFG_SCREEN_HEIGHT)
                    scr_h = cfg_data;
            end

            // pixels taken now come from earlier items, so compare before predicting
            if (pix_valid && !pix_stall)
            begin
                got = {pixel_x, pixel_y, pixel_color, on_screen, last};
                if (pixel_q.size() == 0)
                    report_mismatch($sformatf("pixel (%0d,%0d) given with none expected",
                                              got.x, got.y));
                else
                begin
                    want = pixel_q.pop_front();
                    pixels_checked++;
                    bad  = "";
                    if (got.x !== want.x)           bad = {bad, " pixel_x"};
                    if (got.y !== want.y)           bad = {bad, " pixel_y"};
                    if (got.color !== want.color)   bad = {bad, " pixel_color"};
                    if (got.on_scr !== want.on_scr) bad = {bad, " on_screen"};
                    if (got.last !== want.last)     bad = {bad, " last"};
                    if (bad != "")
                        report_mismatch($sformatf(
                            "%s: got (%0d,%0d) %h on=%b last=%b, want (%0d,%0d) %h on=%b last=%b",
                            bad, got.x, got.y, got.color, got.on_scr, got.last,
                            want.x, want.y, want.color, want.on_scr, want.last));
                end
            end

            if (cmd_valid && !cmd_stall)
            begin
                if (opcode == OP_START)
                    lines_started++;
                if (step_line(opcode_t'(opcode), fresh))
                    pixel_q.push_back(fresh);
            end

            outstanding <= pixel_q.size();
        end
    end

endmodule

/* dv/bresenham_line_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_generator_tb
// Drives lines of all orientations through the generator: a directed set of
// corner cases, then random lines under six screen sizes. Commands come in
// bursts with gaps and the pixel side stalls on shifting patterns; a checker
// beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module bresenham_line_generator_tb;
    import blg_pkg::*;

    localparam int COORD_BITS      = 9;
    localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
    localparam int CYCLE_LIMIT     = 200_000;
    localparam int ITEMS_PER_PHASE = 60;

    logic                      clk;
    logic                      rst_n       = 1'b0;
    logic                      cmd_valid   = 1'b0;
    logic                      cmd_stall;
    logic                      opcode      = OP_START;
    logic [COORD_BITS-1:0]     start_x     = '0;
    logic [COORD_BITS-1:0]     start_y     = '0;
    logic [COORD_BITS-1:0]     end_x       = '0;
    logic [COORD_BITS-1:0]     end_y       = '0;
    logic [COLOR_BITS-1:0]     pen_color   = '0;
    logic                      pix_valid;
    logic                      pix_stall   = 1'b0;
    logic [COORD_BITS-1:0]     pixel_x;
    logic [COORD_BITS-1:0]     pixel_y;
    logic [COLOR_BITS-1:0]     pixel_color;
    logic                      on_screen;
    logic                      last;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = CFG_SCREEN_WIDTH;
    logic [SIZE_BITS-1:0]      cfg_data    = '0;

    int mismatches;
    int outstanding;
    int pixels_checked;
    int lines_started;

    int          burst_left      = 0;
    int          items_sent      = 0;
    int          screen_settings = 0;
    int          cur_w           = SCREEN_WIDTH_RST;
    int          cur_h           = SCREEN_HEIGHT_RST;
    int          stall_mode      = 0;
    int          mode_left       = 0;
    int unsigned stall_tick      = 0;
    int unsigned cycle_count     = 0;

    bresenham_line_generator #(.COORD_BITS(COORD_BITS)) i_dut (.*);

    bresenham_line_checker #(.COORD_BITS(COORD_BITS)) i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels still expected",
                     cycle_count, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // pixel side: free flow, light or heavy random stalls, or a fixed rhythm
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(32, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       pix_stall <= 1'b0;
            1:       pix_stall <= ($urandom_range(0, 9) < 3);
            2:       pix_stall <= ($urandom_range(0, 9) < 7);
            default: pix_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    task automatic put_cmd(input opcode_t op, input int sx, input int sy,
                           input int ex, input int ey, input int col);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        opcode    <= op;
        start_x   <= COORD_BITS'(sx);
        start_y   <= COORD_BITS'(sy);
        end_x     <= COORD_BITS'(ex);
        end_y     <= COORD_BITS'(ey);
        pen_color <= COLOR_BITS'(col);
        do
            @(posedge clk);
        while (cmd_stall);
        items_sent++;
    endtask

    // advance items carry junk in the unused fields
    task automatic advance(input int n);
        repeat (n)
            put_cmd(OP_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic draw(input int sx, input int sy, input int ex, input int ey,
                        input int col, input int n_adv);
        put_cmd(OP_START, sx, sy, ex, ey, col);
        advance(n_adv);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic set_screen(input int w, input int h);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= SIZE_BITS'(w);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= SIZE_BITS'(h);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
        screen_settings++;
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // anywhere, hugging either end of the range, or close to the screen border
    function automatic int pick_coord(input int border);
        case ($urandom_range(0, 5))
            0, 1:    return $urandom_range(0, COORD_MAX);
            2:       return $urandom_range(0, 3);
            3:       return $urandom_range(COORD_MAX - 3, COORD_MAX);
            default: return clamp_coord(border + int'($urandom_range(0, 4)) - 2);
        endcase
    endfunction

    function automatic int line_pixels(input int sx, input int sy, input int ex, input int ey);
        int dx;
        int dy;
        dx = (ex > sx) ? ex - sx : sx - ex;
        dy = (ey > sy) ? ey - sy : sy - ey;
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    // mostly whole short lines; some lines cut off by the next start, some
    // stray advances
    task automatic run_random(input int target);
        int counted;
        int pick;
        int sx;
        int sy;
        int ex;
        int ey;
        int span;
        int n;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                sx   = pick_coord(cur_w);
                sy   = pick_coord(cur_h);
                span = ($urandom_range(0, 7) == 0) ? 24 : 5;
                ex   = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
                ey   = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
                n    = line_pixels(sx, sy, ex, ey);
                draw(sx, sy, ex, ey, $urandom, n);
                counted += n + 1;
                if ($urandom_range(0, 9) == 0)
                begin
                    n = $urandom_range(1, 2);
                    advance(n);
                    counted += n;
                end
            end
            else if (pick < 90)
            begin
                n = $urandom_range(0, 6);
                draw($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom, n);
                counted += n + 1;
            end
            else
            begin
                n = $urandom_range(1, 3);
                advance(n);
                counted += n;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        advance(1);                                          // no line loaded yet
        draw(0, 0, 0, 0, 16'h0000, 2);                       // single point, then idle
        draw(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF, 1);
        draw(238, 318, 241, 321, 16'hF800, 4);               // diagonal over both borders
        draw(5, 2, 5, 0, 16'h07E0, 3);                       // vertical, y falling
        draw(3, 0, 1, 4, 16'h001F, 5);                       // steep, x falling
        draw(20, 20, 30, 20, 16'hAAAA, 2);                   // horizontal, dropped by restart
        draw(0, COORD_MAX, 2, COORD_MAX - 1, 16'h5555, 3);   // shallow, y falling

        run_random(ITEMS_PER_PHASE);
        set_screen(1, 512);
        run_random(ITEMS_PER_PHASE);
        set_screen(512, 1);
        run_random(ITEMS_PER_PHASE);
        set_screen($urandom_range(2, 511), $urandom_range(2, 511));
        run_random(ITEMS_PER_PHASE);
        set_screen(1, 1);
        run_random(ITEMS_PER_PHASE);
        set_screen(512, 512);
        run_random(ITEMS_PER_PHASE);

        drain();
        repeat (8) @(posedge clk);

        $display("summary: %0d command items taken, %0d lines started, %0d pixels compared",
                 items_sent, lines_started, pixels_checked);
        $display("summary: default screen plus %0d sizes written, 1 and 512 on both axes",
                 screen_settings);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
